/* src/transposition_table_core_assert.svh */
// Assertion macros for the transposition table core.
// Plain text macros; no dependencies. Included by the top level only.
`ifndef TRANSPOSITION_TABLE_CORE_ASSERT_SVH
`define TRANSPOSITION_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transposition table core: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define TTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transposition table core: next-cycle check failed");

`endif

/* src/ttc_pkg.sv */
// Shared types and constants of the transposition table core.
// No dependencies; used by every module of the block.
package ttc_pkg;

  localparam int KEY_W       = 64;
  localparam int MOD_STEPS   = 4;                 // key bits folded per cycle
  localparam int MOD_CYCLES  = KEY_W / MOD_STEPS;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [5:0] MAX_DEPTH_RESET = 6'd20;
  localparam logic signed [15:0] SCORE_NONE = -16'sd1;

  typedef enum logic [1:0] {
    KIND_SEARCH_PROBE  = 2'd0,
    KIND_SEARCH_RECORD = 2'd1,
    KIND_PERFT_PROBE   = 2'd2,
    KIND_PERFT_RECORD  = 2'd3
  } kind_t;

  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [63:0]        position_key;
    logic [5:0]         depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] score_in;
    logic [1:0]         bound_kind;
    logic [15:0]        best_move;
    logic [63:0]        node_count;
  } item_t;

  typedef struct packed {
    logic [63:0]        key;
    logic [5:0]         depth;
    logic [1:0]         bound;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic [63:0]        nodes;
  } entry_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic               key_matched;
    logic [15:0]        move_out;
    logic               move_valid;
    logic [63:0]        nodes_out;
  } result_t;

endpackage

/* src/ttc_queue.sv */
// Short FIFO between the front and back parts of the transposition table core.
// Depends on ttc_pkg for its depth.
module ttc_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = (ttc_pkg::QUEUE_DEPTH > 1) ? $clog2(ttc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ttc_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ttc_pkg::QUEUE_DEPTH - 1);

  logic [W-1:0]     slot_r [ttc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(ttc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/ttc_front.sv */
// Front part: accepts items, reduces the key to a table slot, feeds the queue.
// Depends on ttc_pkg for the item type and the key-reduction constants.
module ttc_front #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int IDX_W         = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clearing,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ttc_pkg::item_t       in_item,
  output logic                 push_valid,
  input  logic                 push_ready,
  output logic [IDX_W-1:0]     push_slot,
  output ttc_pkg::item_t       push_item
);

  logic           hold_v_r;
  ttc_pkg::item_t hold_r;
  logic           done;
  logic           accept;
  logic           push_fire;

  assign push_valid = hold_v_r && done;
  assign push_fire  = push_valid && push_ready;
  assign in_ready   = !clearing && (!hold_v_r || push_fire);
  assign accept     = in_valid && in_ready;
  assign push_item  = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (accept) begin
      hold_v_r <= 1'b1;
    end else if (push_fire) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= in_item;
    end
  end

  if ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0) begin : g_pow2
    // Slot is the low key bits.
    assign done      = 1'b1;
    assign push_slot = hold_r.position_key[IDX_W-1:0];
  end else begin : g_mod
    // Restoring remainder, MOD_STEPS key bits per cycle, most significant first.
    localparam int CNT_W = $clog2(ttc_pkg::MOD_CYCLES + 1);
    localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(TABLE_ENTRIES);

    logic [IDX_W-1:0] rem_r, rem_nxt;
    logic [63:0]      sh_r, sh_nxt;
    logic [CNT_W-1:0] cnt_r;
    logic [IDX_W:0]   acc;

    always_comb begin
      acc    = {1'b0, rem_r};
      sh_nxt = sh_r;
      for (int i = 0; i < ttc_pkg::MOD_STEPS; i++) begin
        acc    = {acc[IDX_W-1:0], sh_nxt[63]};
        sh_nxt = {sh_nxt[62:0], 1'b0};
        if (acc >= MODULUS) begin
          acc = acc - MODULUS;
        end
      end
      rem_nxt = acc[IDX_W-1:0];
    end

    assign done      = (cnt_r == CNT_W'(ttc_pkg::MOD_CYCLES));
    assign push_slot = rem_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r <= '0;
      end else if (accept) begin
        cnt_r <= '0;
      end else if (hold_v_r && !done) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        rem_r <= '0;
        sh_r  <= in_item.position_key;
      end else if (hold_v_r && !done) begin
        rem_r <= rem_nxt;
        sh_r  <= sh_nxt;
      end
    end
  end

endmodule

/* src/ttc_back.sv */
// Back part: table memory, clearing pass, probe evaluation, record writes, result register.
// Depends on ttc_pkg for item, entry and result types and the state enum.
module ttc_back #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int IDX_W         = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [5:0]         max_depth,
  input  logic               q_valid,
  output logic               q_ready,
  input  logic [IDX_W-1:0]   q_slot,
  input  ttc_pkg::item_t     q_item,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output ttc_pkg::result_t   out_result
);

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

  ttc_pkg::entry_t      mem [TABLE_ENTRIES];
  ttc_pkg::entry_t      rd_data_r;
  ttc_pkg::item_t       cur_r;
  logic [IDX_W-1:0]     cur_slot_r;
  logic [IDX_W-1:0]     clr_cnt_r;
  ttc_pkg::back_state_t state_r, state_nxt;

  logic               pop, exec_fire, is_record, mem_we;
  logic [IDX_W-1:0]   mem_wa;
  ttc_pkg::entry_t    mem_wd, merged;
  ttc_pkg::result_t   res;
  logic               key_hit, depth_hit;
  logic signed [15:0] st_score;

  logic               out_valid_r;
  ttc_pkg::result_t   out_result_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttc_pkg::BK_CLEAR: if (clr_cnt_r == LAST_SLOT) state_nxt = ttc_pkg::BK_IDLE;
      ttc_pkg::BK_IDLE:  if (q_valid) state_nxt = ttc_pkg::BK_EXEC;
      ttc_pkg::BK_EXEC:  if (exec_fire) state_nxt = ttc_pkg::BK_IDLE;
      default:           state_nxt = ttc_pkg::BK_CLEAR;
    endcase
  end

  // Control outputs.
  always_comb begin
    clearing  = (state_r == ttc_pkg::BK_CLEAR);
    q_ready   = (state_r == ttc_pkg::BK_IDLE);
    exec_fire = (state_r == ttc_pkg::BK_EXEC) && (!out_valid_r || out_ready);
  end

  assign pop       = q_ready && q_valid;
  assign is_record = (cur_r.kind == ttc_pkg::KIND_SEARCH_RECORD) ||
                     (cur_r.kind == ttc_pkg::KIND_PERFT_RECORD);
  assign mem_we    = clearing || (exec_fire && is_record);
  assign mem_wa    = clearing ? clr_cnt_r : cur_slot_r;
  assign mem_wd    = clearing ? '0 : merged;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ttc_pkg::BK_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r  <= mem[q_slot];
      cur_r      <= q_item;
      cur_slot_r <= q_slot;
    end
  end

  assign st_score  = rd_data_r.score;
  assign key_hit   = (rd_data_r.key == cur_r.position_key);
  assign depth_hit = ({1'b0, rd_data_r.depth} + {1'b0, cur_r.depth}) == {1'b0, max_depth};

  always_comb begin
    res    = '0;
    merged = rd_data_r;
    unique case (cur_r.kind)
      ttc_pkg::KIND_SEARCH_PROBE: begin
        res.score = ttc_pkg::SCORE_NONE;
        if (key_hit) begin
          res.key_matched = 1'b1;
          res.move_out    = rd_data_r.move;
          res.move_valid  = 1'b1;
          if (depth_hit) begin
            priority if (rd_data_r.bound == ttc_pkg::BOUND_EXACT) begin
              res.score = st_score;
            end else if (rd_data_r.bound == ttc_pkg::BOUND_UPPER && st_score <= cur_r.alpha) begin
              res.score = cur_r.alpha;
            end else if (rd_data_r.bound == ttc_pkg::BOUND_LOWER && st_score >= cur_r.beta) begin
              res.score = cur_r.beta;
            end else begin
              res.score = ttc_pkg::SCORE_NONE;
            end
          end
        end
      end
      ttc_pkg::KIND_SEARCH_RECORD: begin
        merged.key   = cur_r.position_key;
        merged.depth = cur_r.depth;
        merged.bound = cur_r.bound_kind;
        merged.score = cur_r.score_in;
        merged.move  = cur_r.best_move;
      end
      ttc_pkg::KIND_PERFT_PROBE: begin
        if (key_hit) begin
          res.key_matched = 1'b1;
          if (rd_data_r.depth == cur_r.depth) begin
            res.nodes_out = rd_data_r.nodes;
          end
        end
      end
      ttc_pkg::KIND_PERFT_RECORD: begin
        merged.key   = cur_r.position_key;
        merged.depth = cur_r.depth;
        merged.nodes = cur_r.node_count;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_result_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

/* src/transposition_table_core.sv */
// Top level of the direct-mapped transposition table core.
// Depends on ttc_pkg, ttc_front, ttc_queue, ttc_back and the assertion macro header.
//
// Use: each item on the in_ stream is a search probe, search record, perft probe
// or perft record (in_tuser). Every item gives exactly one result on the out_
// stream, in order; records answer with all fields zero.
// Key reduction is a bit select when the table size is a power of two.
// The back part handles one item at a time: it reads the slot when it pops the
// queue, then evaluates it and writes a record back, and pops no new item until
// that result is in the output register.
// With a table size that is not a power of two, the front's remainder unit
// folds four key bits a cycle and accepts no new item until the slot is reduced
// and pushed to the queue.
// Reset: max_depth returns to 20 and a clearing pass writes zero to every slot,
// one per cycle; in_tready stays low meanwhile.
// Configuration writes are taken at any time.
// Stall: results wait in an output register while out_tready is low; the front
// keeps accepting into its hold stage and the two-entry queue until they fill.
`include "transposition_table_core_assert.svh"

module transposition_table_core #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration: max_depth
  input  logic         cfg_wr_en,
  input  logic [5:0]   cfg_wr_data,
  // Input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata, low bit up: position_key[63:0], depth[69:64], alpha[85:70],
  // beta[101:86], score_in[117:102], bound_kind[119:118], best_move[135:120],
  // node_count[199:136]
  input  logic [199:0] in_tdata,
  // in_tuser: kind[1:0]
  input  logic [1:0]   in_tuser,
  // Result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata, low bit up: score[15:0], move_out[31:16], nodes_out[95:32]
  output logic [95:0]  out_tdata,
  // out_tuser, low bit up: key_matched[0], move_valid[1]
  output logic [1:0]   out_tuser
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int QW    = IDX_W + $bits(ttc_pkg::item_t);

  logic             clearing_d_r;
  logic [5:0]       max_depth_q_r;
  ttc_pkg::item_t   in_item;
  logic             clearing;

  logic             push_valid, push_ready;
  logic [IDX_W-1:0] push_slot;
  ttc_pkg::item_t   push_item;

  logic             pop_valid, pop_ready;
  logic [QW-1:0]    pop_data;
  logic [IDX_W-1:0] q_slot;
  ttc_pkg::item_t   q_item;

  ttc_pkg::result_t out_result;

  // Hold the search depth offset; written whenever the enable is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_depth_q_r <= ttc_pkg::MAX_DEPTH_RESET;
    end else if (cfg_wr_en) begin
      max_depth_q_r <= cfg_wr_data;
    end
  end

  // Registered copy of the flag that the table is being swept; used by the checks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_d_r <= 1'b1;
    end else begin
      clearing_d_r <= clearing;
    end
  end

  // Unpack the input stream.
  assign in_item.kind         = ttc_pkg::kind_t'(in_tuser);
  assign in_item.position_key = in_tdata[63:0];
  assign in_item.depth        = in_tdata[69:64];
  assign in_item.alpha        = in_tdata[85:70];
  assign in_item.beta         = in_tdata[101:86];
  assign in_item.score_in     = in_tdata[117:102];
  assign in_item.bound_kind   = in_tdata[119:118];
  assign in_item.best_move    = in_tdata[135:120];
  assign in_item.node_count   = in_tdata[199:136];

  ttc_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .clearing   (clearing),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_slot  (push_slot),
    .push_item  (push_item)
  );

  ttc_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_slot, push_item}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign q_slot = pop_data[QW-1 -: IDX_W];
  assign q_item = ttc_pkg::item_t'(pop_data[$bits(ttc_pkg::item_t)-1:0]);

  ttc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_depth  (max_depth_q_r),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_slot     (q_slot),
    .q_item     (q_item),
    .clearing   (clearing),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  // Pack the result stream.
  assign out_tdata = {out_result.nodes_out, out_result.move_out, out_result.score};
  assign out_tuser = {out_result.move_valid, out_result.key_matched};

  // No item enters while the table is being swept.
  `TTC_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, clearing, !in_tready)
  // No result can exist before the sweep has ended.
  `TTC_ASSERT_IMP(a_no_result_in_clear, clk, rst_n, clearing_d_r, !out_tvalid)
  // A returned move implies a key match.
  `TTC_ASSERT_IMP(a_move_needs_match, clk, rst_n, out_tvalid && out_tuser[1], out_tuser[0])
  // A node count comes only from a matching perft probe, never with a move.
  `TTC_ASSERT_IMP(a_nodes_need_match, clk, rst_n, out_tvalid && (out_tdata[95:32] != 64'd0),
                  out_tuser[0] && !out_tuser[1])

endmodule
